// ===== rtl/npcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package npcm_pkg;

    // Field widths
    localparam int CHAN_W      = 8;
    localparam int IDX_OUT_W   = 8;
    localparam int SQ_W        = 2 * CHAN_W;
    localparam int DIST_W      = 18;
    localparam int CFG_W       = 9;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    // Item kinds carried on tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    // One RGB color or palette entry
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // Per-channel squared differences
    typedef struct packed {
        logic [SQ_W-1:0] sq_red;
        logic [SQ_W-1:0] sq_green;
        logic [SQ_W-1:0] sq_blue;
    } t_sq;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/npcm_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module npcm_dist #(
    parameter int IDX_W = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_vld,
    input  wire [IDX_W-1:0]      i_idx,
    input  npcm_pkg::t_rgb       i_color,
    input  npcm_pkg::t_rgb       i_entry,
    output logic                 o_vld,
    output logic [IDX_W-1:0]     o_idx,
    output npcm_pkg::t_sq        o_sq
);
    import npcm_pkg::*;

    logic [CHAN_W-1:0] d_red;
    logic [CHAN_W-1:0] d_green;
    logic [CHAN_W-1:0] d_blue;

    // Take absolute channel differences
    always_comb begin
        d_red   = (i_color.red > i_entry.red) ? (i_color.red - i_entry.red)
                                              : (i_entry.red - i_color.red);
        d_green = (i_color.green > i_entry.green) ? (i_color.green - i_entry.green)
                                                  : (i_entry.green - i_color.green);
        d_blue  = (i_color.blue > i_entry.blue) ? (i_color.blue - i_entry.blue)
                                                : (i_entry.blue - i_color.blue);
    end

    // Track which stage holds a live item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

    // Register squares and the entry tag
    always_ff @(posedge i_clk) begin
        o_idx           <= i_idx;
        o_sq.sq_red     <= SQ_W'(d_red * d_red);
        o_sq.sq_green   <= SQ_W'(d_green * d_green);
        o_sq.sq_blue    <= SQ_W'(d_blue * d_blue);
    end

endmodule

`default_nettype wire

// ===== rtl/nearest_palette_color_match_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Nearest palette color match. Holds PALETTE_DEPTH RGB entries (8 bits per
// channel, all black after reset). An item with tuser = 0 writes entry
// tdata[7:0] (ignored beyond the depth) and gives no result, staying idle.
// An item with tuser = 1 scans entries 0 to palette_count-1 (saturated at the
// depth) and returns the lowest index of least squared RGB distance, with that
// distance; an empty palette returns index 0 and distance 0. With the output
// register free, a match presents its result once its scan has drained and
// the finish state has loaded the output register (an empty palette skips the
// scan), and the input is ready again in that same cycle: one entry a cycle
// leaves the single read port of the palette memory and goes through one
// shared distance unit and compare; the input is not ready during the scan. A
// result may wait on the output register while the next item is taken. Write
// palette_count only while no match is in progress.
module nearest_palette_color_match_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Palette count register write
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [npcm_pkg::CFG_W-1:0]          i_cfg_data,
    // Input items
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  wire  [npcm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation[0]
    input  wire                                 s_axis_tuser,
    // Result items
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // nearest_index[7:0], nearest_distance_sq[25:8], zero[31:26]
    output logic [npcm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import npcm_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    t_state                 r_state;
    t_state                 n_state;

    logic [CFG_W-1:0]       r_palette_count;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_scan_cnt;
    logic [CNT_W-1:0]       sat_count;
    t_rgb                   r_color;

    t_rgb                   r_mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] r_ent_vld;

    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx;
    t_rgb                   r_rd_data;
    logic                   r_rd_ent_vld;
    t_rgb                   rd_entry;
    logic [IDX_W-1:0]       rd_addr;

    logic                   dist_vld;
    logic [IDX_W-1:0]       dist_idx;
    t_sq                    dist_sq;
    logic [DIST_W-1:0]      dist_sum;

    logic                   r_found;
    logic [IDX_W-1:0]       r_best_idx;
    logic [DIST_W-1:0]      r_best_dist;

    logic                   in_acc;
    logic                   cfg_acc;
    logic                   issue;
    logic                   out_load;
    logic [CHAN_W-1:0]      in_idx;
    t_rgb                   in_rgb;
    logic                   wr_en;

    // Unpack the input item
    assign in_idx       = s_axis_tdata[7:0];
    assign in_rgb.red   = s_axis_tdata[15:8];
    assign in_rgb.green = s_axis_tdata[23:16];
    assign in_rgb.blue  = s_axis_tdata[31:24];

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign wr_en   = in_acc && (s_axis_tuser == OP_LOAD)
                     && ({1'b0, in_idx} < CFG_W'(PALETTE_DEPTH));
    assign rd_addr = r_scan_cnt[IDX_W-1:0];

    // Saturate the entry count at the depth
    assign sat_count = (r_palette_count > CFG_W'(PALETTE_DEPTH))
                       ? CNT_W'(PALETTE_DEPTH) : CNT_W'(r_palette_count);

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        o_cfg_ready   = 1'b0;
        issue         = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cfg_ready   = 1'b1;
                if (in_acc && (s_axis_tuser == OP_MATCH)) begin
                    n_state = (sat_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue = (r_scan_cnt != r_count);
                if (!issue && !r_rd_vld && !dist_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_axis_tvalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the palette count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_count <= '0;
        end else if (cfg_acc) begin
            r_palette_count <= i_cfg_data;
        end
    end

    // Latch the match color and count, step the scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_count    <= '0;
        end else if (in_acc && (s_axis_tuser == OP_MATCH)) begin
            r_scan_cnt <= '0;
            r_count    <= sat_count;
        end else if (issue) begin
            r_scan_cnt <= r_scan_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (s_axis_tuser == OP_MATCH)) begin
            r_color <= in_rgb;
        end
    end

    // Write and read the palette memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[in_idx[IDX_W-1:0]] <= in_rgb;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Mark written entries; unwritten ones read as black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (wr_en) begin
            r_ent_vld[in_idx[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= rd_addr;
        r_rd_ent_vld <= r_ent_vld[rd_addr];
    end

    assign rd_entry = r_rd_ent_vld ? r_rd_data : '0;

    // Square the channel differences
    npcm_dist #(
        .IDX_W   (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_idx   (r_rd_idx),
        .i_color (r_color),
        .i_entry (rd_entry),
        .o_vld   (dist_vld),
        .o_idx   (dist_idx),
        .o_sq    (dist_sq)
    );

    assign dist_sum = DIST_W'(dist_sq.sq_red) + DIST_W'(dist_sq.sq_green)
                      + DIST_W'(dist_sq.sq_blue);

    // Keep the running best; strict compare leaves ties on the lower index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (in_acc && (s_axis_tuser == OP_MATCH)) begin
            r_found <= 1'b0;
        end else if (dist_vld) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (s_axis_tuser == OP_MATCH)) begin
            r_best_idx  <= '0;
            r_best_dist <= '1;
        end else if (dist_vld && (!r_found || (dist_sum < r_best_dist))) begin
            r_best_idx  <= dist_idx;
            r_best_dist <= dist_sum;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (out_load) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            m_axis_tdata <= {
                (OUT_TDATA_W - DIST_W - IDX_OUT_W)'(0),
                (r_found ? r_best_dist : DIST_W'(0)),
                IDX_OUT_W'(r_best_idx)
            };
        end
    end

    // Scan never runs past the saturated count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan_cnt <= r_count))
        else $error("scan counter passed the entry count");

    // A finished scan has seen an entry exactly when the palette is not empty
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_found == (r_count != '0)))
        else $error("best-match flag disagrees with entry count");

    // Results appear only out of the finish state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the finish state");

    // Nothing is left in flight when the scan ends
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_rd_vld && !dist_vld))
        else $error("scan ended with entries still in the pipeline");

endmodule

`default_nettype wire
